@@ rtl/core/ipc_pkg.sv @@
// Shared types, ink codes and register indexes for the ink pixel compositor.
package ipc_pkg;

    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam int IDX_W = 3;

    localparam logic [PIX_W-1:0] COL_BLACK = 24'h000000;
    localparam logic [PIX_W-1:0] COL_WHITE = 24'hFFFFFF;

    // ink codes
    localparam logic [5:0] INK_COPY        = 6'd0;
    localparam logic [5:0] INK_TRANSP      = 6'd1;
    localparam logic [5:0] INK_REVERSE     = 6'd2;
    localparam logic [5:0] INK_GHOST       = 6'd3;
    localparam logic [5:0] INK_NOT_COPY    = 6'd4;
    localparam logic [5:0] INK_NOT_TRANSP  = 6'd5;
    localparam logic [5:0] INK_NOT_REVERSE = 6'd6;
    localparam logic [5:0] INK_NOT_GHOST   = 6'd7;
    localparam logic [5:0] INK_MATTE       = 6'd8;
    localparam logic [5:0] INK_MASK        = 6'd9;
    localparam logic [5:0] INK_BLEND       = 6'd32;
    localparam logic [5:0] INK_ADD_PIN     = 6'd33;
    localparam logic [5:0] INK_ADD         = 6'd34;
    localparam logic [5:0] INK_SUB_PIN     = 6'd35;
    localparam logic [5:0] INK_BG_TRANSP   = 6'd36;
    localparam logic [5:0] INK_LIGHTEN     = 6'd37;
    localparam logic [5:0] INK_SUB         = 6'd38;
    localparam logic [5:0] INK_DARKEN      = 6'd39;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_INK_MODE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_FORE_COLOR  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BACK_COLOR  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ONE_BIT     = 3'd3;
    localparam logic [IDX_W-1:0] REG_BLEND_ALPHA = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEXT_SPRITE = 3'd5;

    typedef struct packed {
        logic [5:0]       ink_mode;
        logic [PIX_W-1:0] fore_color;
        logic [PIX_W-1:0] back_color;
        logic             one_bit_image;
        logic [CH_W-1:0]  blend_alpha;
        logic             text_sprite;
    } cfg_t;

endpackage

@@ rtl/core/ink_pixel_compositor.sv @@
// Top level of the ink pixel compositor: config registers and pipeline control.
// A taken pixel passes the stage-1, stage-2 and output registers to out_pixel.
// Throughput: one pixel per clock; busy stays low, the pipeline never stalls.
// Stages: text remap, ink logic and blend products, divide by 255 and select.
// Reset: rst_n clears valid bits and restores register defaults (back white).
// The receiver cannot stall: each result shows for exactly one cycle.
module ink_pixel_compositor
    import ipc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [PIX_W-1:0] src_pixel,
    input  logic [PIX_W-1:0] dst_pixel,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_index,
    input  logic [PIX_W-1:0] wr_data,
    output logic             done,
    output logic [PIX_W-1:0] out_pixel
);

    cfg_t             cfg_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic [PIX_W-1:0] s1;
    logic [PIX_W-1:0] d1;
    logic [PIX_W-1:0] ink_q;
    logic [PIX_W-1:0] blend_q;
    logic [PIX_W-1:0] out_reg;
    logic [PIX_W-1:0] out_next;
    logic             in_xfer;

    // every cycle can take a new pixel
    assign busy    = 1'b0;
    assign in_xfer = start && !busy;

    // configuration registers; out-of-range index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ink_mode      <= INK_COPY;
            cfg_reg.fore_color    <= COL_BLACK;
            cfg_reg.back_color    <= COL_WHITE;
            cfg_reg.one_bit_image <= 1'b0;
            cfg_reg.blend_alpha   <= '0;
            cfg_reg.text_sprite   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_INK_MODE:    cfg_reg.ink_mode      <= wr_data[5:0];
                REG_FORE_COLOR:  cfg_reg.fore_color    <= wr_data;
                REG_BACK_COLOR:  cfg_reg.back_color    <= wr_data;
                REG_ONE_BIT:     cfg_reg.one_bit_image <= wr_data[0];
                REG_BLEND_ALPHA: cfg_reg.blend_alpha   <= wr_data[CH_W-1:0];
                REG_TEXT_SPRITE: cfg_reg.text_sprite   <= wr_data[0];
                default:         ;
            endcase
        end
    end

    // stage 1
    ipc_prep u_prep (
        .clk       (clk),
        .cfg       (cfg_reg),
        .src_pixel (src_pixel),
        .dst_pixel (dst_pixel),
        .s_reg     (s1),
        .d_reg     (d1)
    );

    // stage 2 ink result
    ipc_ink u_ink (
        .clk     (clk),
        .cfg     (cfg_reg),
        .s       (s1),
        .d       (d1),
        .ink_reg (ink_q)
    );

    // stage 2 products, stage 3 divide
    ipc_blend u_blend (
        .clk   (clk),
        .alpha (cfg_reg.blend_alpha),
        .s     (s1),
        .d     (d1),
        .blend (blend_q)
    );

    // nonzero alpha overrides the ink
    assign out_next = (cfg_reg.blend_alpha != '0) ? blend_q : ink_q;

    // valid bits travel alongside the payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_xfer;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // one-cycle result transfer
    assign done      = v3_reg;
    assign out_pixel = out_reg;

endmodule

@@ rtl/core/ipc_prep.sv @@
// Stage 1: text source remap, registers source and destination pixels.
module ipc_prep
    import ipc_pkg::*;
(
    input  logic             clk,
    input  cfg_t             cfg,
    input  logic [PIX_W-1:0] src_pixel,
    input  logic [PIX_W-1:0] dst_pixel,
    output logic [PIX_W-1:0] s_reg,
    output logic [PIX_W-1:0] d_reg
);

    logic [PIX_W-1:0] remap;
    logic [PIX_W-1:0] s_next;

    always_comb
    begin
        unique case (cfg.ink_mode)
            INK_MASK:        remap = (src_pixel == cfg.back_color) ? cfg.fore_color
                                                                   : 24'h0000FF;
            INK_REVERSE:     remap = (src_pixel == cfg.fore_color) ? COL_BLACK : COL_WHITE;
            INK_NOT_REVERSE: remap = (src_pixel == cfg.back_color) ? COL_WHITE : COL_BLACK;
            INK_NOT_GHOST:   remap = (src_pixel == cfg.back_color) ? COL_WHITE
                                                                   : cfg.back_color;
            INK_NOT_COPY:    remap = (src_pixel == cfg.fore_color) ? cfg.back_color
                                                                   : cfg.fore_color;
            INK_NOT_TRANSP:  remap = (src_pixel == cfg.fore_color) ? cfg.back_color
                                                                   : COL_WHITE;
            default:         remap = src_pixel;
        endcase
        s_next = cfg.text_sprite ? remap : src_pixel;
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        d_reg <= dst_pixel;
    end

endmodule

@@ rtl/core/ipc_ink.sv @@
// Stage 2: ink mode logic, bitwise and per-channel arithmetic inks.
module ipc_ink
    import ipc_pkg::*;
(
    input  logic             clk,
    input  cfg_t             cfg,
    input  logic [PIX_W-1:0] s,
    input  logic [PIX_W-1:0] d,
    output logic [PIX_W-1:0] ink_reg
);

    logic             ac;
    logic             alt;
    logic [PIX_W-1:0] arith;
    logic [PIX_W-1:0] ink_next;

    // colorize flag
    always_comb
    begin
        unique case (cfg.ink_mode)
            INK_COPY, INK_NOT_COPY, INK_MATTE, INK_MASK, INK_TRANSP, INK_GHOST,
            INK_NOT_TRANSP, INK_NOT_GHOST, INK_BG_TRANSP:
                ac = !cfg.text_sprite &&
                     (cfg.fore_color != COL_BLACK || cfg.back_color != COL_WHITE);
            default:
                ac = 1'b0;
        endcase
        alt = cfg.one_bit_image || ac;
    end

    // per-channel arithmetic, channels independent
    always_comb
    begin
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        logic [CH_W:0]   sum;
        arith = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            a   = s[ch*CH_W +: CH_W];
            b   = d[ch*CH_W +: CH_W];
            sum = {1'b0, a} + {1'b0, b};
            unique case (cfg.ink_mode)
                INK_ADD_PIN: arith[ch*CH_W +: CH_W] = sum[CH_W] ? 8'hFF : sum[CH_W-1:0];
                INK_ADD:     arith[ch*CH_W +: CH_W] = sum[CH_W-1:0];
                INK_SUB_PIN: arith[ch*CH_W +: CH_W] = (b > a) ? (b - a - 8'd1) : 8'd0;
                INK_LIGHTEN: arith[ch*CH_W +: CH_W] = (a > b) ? a : b;
                INK_SUB:     arith[ch*CH_W +: CH_W] = b - a;
                default:     arith[ch*CH_W +: CH_W] = (a < b) ? a : b;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg.ink_mode)
            INK_BG_TRANSP:
                if (cfg.one_bit_image)
                    ink_next = (s == COL_BLACK) ? cfg.fore_color : d;
                else
                    ink_next = (s == cfg.back_color) ? d : s;
            INK_COPY, INK_MATTE, INK_MASK, INK_BLEND:
                ink_next = ac ? ((s | cfg.fore_color) & (~s | cfg.back_color)) : s;
            INK_NOT_COPY:
                ink_next = ac ? ((~s | cfg.fore_color) & (s | cfg.back_color)) : ~s;
            INK_TRANSP:
                ink_next = alt ? ((s == COL_BLACK) ? cfg.fore_color : d) : (d | s);
            INK_NOT_TRANSP:
                ink_next = alt ? ((s == COL_WHITE) ? cfg.fore_color : d) : (d | ~s);
            INK_REVERSE:
                ink_next = d ^ s;
            INK_NOT_REVERSE:
                ink_next = d ^ ~s;
            INK_GHOST:
                ink_next = alt ? ((s == COL_BLACK) ? cfg.back_color : d) : (d & ~s);
            INK_NOT_GHOST:
                ink_next = alt ? ((s == COL_WHITE) ? cfg.back_color : d) : (d & s);
            INK_ADD_PIN, INK_ADD, INK_SUB_PIN, INK_LIGHTEN, INK_SUB, INK_DARKEN:
                ink_next = arith;
            default:
                ink_next = d;
        endcase
    end

    always_ff @(posedge clk)
    begin
        ink_reg <= ink_next;
    end

endmodule

@@ rtl/core/ipc_blend.sv @@
// Stages 2-3: alpha lerp, registered products then divide by 255.
module ipc_blend
    import ipc_pkg::*;
(
    input  logic             clk,
    input  logic [CH_W-1:0]  alpha,
    input  logic [PIX_W-1:0] s,
    input  logic [PIX_W-1:0] d,
    output logic [PIX_W-1:0] blend
);

    logic [2*CH_W-1:0] ps_reg [3];
    logic [2*CH_W-1:0] pd_reg [3];
    logic [CH_W-1:0]   inv_alpha;

    assign inv_alpha = 8'hFF - alpha;

    always_ff @(posedge clk)
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            ps_reg[ch] <= s[ch*CH_W +: CH_W] * alpha;
            pd_reg[ch] <= d[ch*CH_W +: CH_W] * inv_alpha;
        end
    end

    // x / 255 for x <= 255*255: (x + 1 + (x >> 8)) >> 8
    always_comb
    begin
        logic [2*CH_W:0] x;
        logic [2*CH_W:0] q;
        blend = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            x = {1'b0, ps_reg[ch]} + {1'b0, pd_reg[ch]};
            q = x + 17'd1 + {8'd0, x[2*CH_W:CH_W]};
            blend[ch*CH_W +: CH_W] = q[2*CH_W-1:CH_W];
        end
    end

endmodule

@@ sim/tb_ink_pixel_compositor.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ink pixel compositor: directed table, then random phases.
module tb_ink_pixel_compositor;
    import ipc_pkg::*;

    // pipeline depth; allow some slack when draining
    localparam int PIPE_DEPTH = 3;
    localparam int DRAIN_LIMIT = 200;
    localparam int PHASES = 14;
    localparam int PIXELS_PER_PHASE = 50;

    // indexes past the register list; writes there must change nothing
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [PIX_W-1:0] src_pixel = '0;
    logic [PIX_W-1:0] dst_pixel = '0;
    logic             wr_en = 1'b0;
    logic [IDX_W-1:0] wr_index = '0;
    logic [PIX_W-1:0] wr_data = '0;
    logic             done;
    logic [PIX_W-1:0] out_pixel;

    // one row of the directed table
    typedef struct {
        cfg_t             setup;
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
        logic             known;
        logic [PIX_W-1:0] result;
    } row_t;

    cfg_t             shadow_cfg;
    logic [PIX_W-1:0] pending_pixels[$];
    row_t             table_rows[$];
    int               mismatches = 0;
    logic [PIX_W-1:0] want;

    ink_pixel_compositor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .src_pixel (src_pixel),
        .dst_pixel (dst_pixel),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .done      (done),
        .out_pixel (out_pixel)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Safety net against a hung pipeline. The slowest legal run is well under
    // 40 us of simulated time; this is 50x that.
    initial
    begin
        #2_000_000;
        $display("ink_pixel_compositor: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor: new destination pixel for one source/destination pair
    // under a given register setup.
    // ------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] composite_pixel(input cfg_t c,
                                                         input logic [PIX_W-1:0] s_in,
                                                         input logic [PIX_W-1:0] d);
        logic [PIX_W-1:0] s;
        logic [PIX_W-1:0] r;
        logic             tintable;
        logic             tint;
        logic             alt;
        logic [CH_W-1:0]  a;
        logic [CH_W-1:0]  b;
        logic [CH_W:0]    sum;
        int               lerp;
        s = s_in;
        r = '0;

        // text sources are remapped first, to fore/back/black/white or 0000FF
        if (c.text_sprite)
        begin
            case (c.ink_mode)
                INK_MASK:        s = (s == c.back_color) ? c.fore_color : 24'h0000FF;
                INK_REVERSE:     s = (s == c.fore_color) ? COL_BLACK : COL_WHITE;
                INK_NOT_REVERSE: s = (s == c.back_color) ? COL_WHITE : COL_BLACK;
                INK_NOT_GHOST:   s = (s == c.back_color) ? COL_WHITE : c.back_color;
                INK_NOT_COPY:    s = (s == c.fore_color) ? c.back_color : c.fore_color;
                INK_NOT_TRANSP:  s = (s == c.fore_color) ? c.back_color : COL_WHITE;
                default:         ;
            endcase
        end

        // colorize applies to the copy-like and transparent-like inks only
        case (c.ink_mode)
            INK_COPY, INK_NOT_COPY, INK_MATTE, INK_MASK, INK_TRANSP, INK_GHOST,
            INK_NOT_TRANSP, INK_NOT_GHOST, INK_BG_TRANSP: tintable = 1'b1;
            default:                                       tintable = 1'b0;
        endcase
        tint = !c.text_sprite && tintable &&
               (c.fore_color != COL_BLACK || c.back_color != COL_WHITE);
        alt = c.one_bit_image || tint;

        // nonzero alpha overrides the ink entirely
        if (c.blend_alpha != '0)
        begin
            for (int sh = 0; sh < PIX_W; sh += CH_W)
            begin
                lerp = (int'(s[sh +: CH_W]) * int'(c.blend_alpha) +
                        int'(d[sh +: CH_W]) * (255 - int'(c.blend_alpha))) / 255;
                r[sh +: CH_W] = lerp[CH_W-1:0];
            end
            return r;
        end

        case (c.ink_mode)
            INK_BG_TRANSP:
                if (c.one_bit_image)
                    r = (s == COL_BLACK) ? c.fore_color : d;
                else
                    r = (s == c.back_color) ? d : s;
            INK_COPY, INK_MATTE, INK_MASK, INK_BLEND:
                r = tint ? ((s | c.fore_color) & (~s | c.back_color)) : s;
            INK_NOT_COPY:
                r = tint ? ((~s | c.fore_color) & (s | c.back_color)) : ~s;
            INK_TRANSP:
                r = alt ? ((s == COL_BLACK) ? c.fore_color : d) : (d | s);
            INK_NOT_TRANSP:
                r = alt ? ((s == COL_WHITE) ? c.fore_color : d) : (d | ~s);
            INK_REVERSE:
                r = d ^ s;
            INK_NOT_REVERSE:
                r = d ^ ~s;
            INK_GHOST:
                r = alt ? ((s == COL_BLACK) ? c.back_color : d) : (d & ~s);
            INK_NOT_GHOST:
                r = alt ? ((s == COL_WHITE) ? c.back_color : d) : (d & s);
            INK_ADD_PIN, INK_ADD, INK_SUB_PIN, INK_LIGHTEN, INK_SUB, INK_DARKEN:
                for (int sh = 0; sh < PIX_W; sh += CH_W)
                begin
                    a = s[sh +: CH_W];
                    b = d[sh +: CH_W];
                    sum = {1'b0, a} + {1'b0, b};
                    case (c.ink_mode)
                        INK_ADD_PIN: r[sh +: CH_W] = sum[CH_W] ? 8'hFF : sum[CH_W-1:0];
                        INK_ADD:     r[sh +: CH_W] = sum[CH_W-1:0];
                        INK_SUB_PIN: r[sh +: CH_W] = (b > a) ? b - a - 8'd1 : 8'd0;
                        INK_LIGHTEN: r[sh +: CH_W] = (a > b) ? a : b;
                        INK_SUB:     r[sh +: CH_W] = b - a;
                        default:     r[sh +: CH_W] = (a < b) ? a : b;
                    endcase
                end
            default:
                r = d;    // unassigned ink codes leave the destination alone
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Checker: every done pulse is matched against the oldest pending pixel.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("out_pixel: expected nothing, actual %h", out_pixel);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (out_pixel !== want)
                begin
                    $error("out_pixel: expected %h, actual %h", want, out_pixel);
                    mismatches++;
                end
            end
        end
    end

    // queue one expected result behind the ones already waiting
    task automatic enqueue_expected(input logic [PIX_W-1:0] px);
        pending_pixels.insert(pending_pixels.size(), px);
    endtask

    task automatic reg_write(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] data);
        @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
    endtask

    // Writes every register. Narrow registers get random junk in the unused
    // upper bits of wr_data, which the block must drop.
    task automatic load_setup(input cfg_t c);
        logic [PIX_W-1:0] junk;
        junk = PIX_W'($urandom);
        reg_write(REG_INK_MODE, {junk[PIX_W-1:6], c.ink_mode});
        reg_write(REG_FORE_COLOR, c.fore_color);
        reg_write(REG_BACK_COLOR, c.back_color);
        junk = PIX_W'($urandom);
        reg_write(REG_ONE_BIT, {junk[PIX_W-1:1], c.one_bit_image});
        junk = PIX_W'($urandom);
        reg_write(REG_BLEND_ALPHA, {junk[PIX_W-1:CH_W], c.blend_alpha});
        junk = PIX_W'($urandom);
        reg_write(REG_TEXT_SPRITE, {junk[PIX_W-1:1], c.text_sprite});
        if ($urandom_range(0, 2) == 0)
            reg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, PIX_W'($urandom));
        @(negedge clk);
        wr_en <= 1'b0;
        shadow_cfg = c;
    endtask

    // Wait until every pending pixel has come back, then let the pipe empty.
    task automatic drain();
        int waited;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_pixels.size() != 0)
        begin
            $error("out_pixel: expected %0d more results, actual none", pending_pixels.size());
            mismatches++;
            pending_pixels.delete();
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    // One transfer. The gap argument sets the idle time before it; start stays high across
    // back-to-back transfers.
    task automatic send_pixel(input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] d,
                              input int gap, input logic known,
                              input logic [PIX_W-1:0] result);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        src_pixel <= s;
        dst_pixel <= d;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        enqueue_expected(known ? result : composite_pixel(shadow_cfg, s, d));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic add_row(input logic [5:0] ink, input logic [PIX_W-1:0] fore,
                           input logic [PIX_W-1:0] back, input logic one_bit,
                           input logic [CH_W-1:0] alpha, input logic text,
                           input logic [PIX_W-1:0] s, input logic [PIX_W-1:0] d,
                           input logic known, input logic [PIX_W-1:0] result);
        row_t row;
        row.setup = '{ink_mode: ink, fore_color: fore, back_color: back,
                      one_bit_image: one_bit, blend_alpha: alpha, text_sprite: text};
        row.src = s;
        row.dst = d;
        row.known = known;
        row.result = result;
        table_rows.insert(table_rows.size(), row);
    endtask

    function automatic logic [5:0] assigned_ink(input int k);
        case (k)
            0:       return INK_COPY;
            1:       return INK_TRANSP;
            2:       return INK_REVERSE;
            3:       return INK_GHOST;
            4:       return INK_NOT_COPY;
            5:       return INK_NOT_TRANSP;
            6:       return INK_NOT_REVERSE;
            7:       return INK_NOT_GHOST;
            8:       return INK_MATTE;
            9:       return INK_MASK;
            10:      return INK_BLEND;
            11:      return INK_ADD_PIN;
            12:      return INK_ADD;
            13:      return INK_SUB_PIN;
            14:      return INK_BG_TRANSP;
            15:      return INK_LIGHTEN;
            16:      return INK_SUB;
            default: return INK_DARKEN;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_color();
        case ($urandom_range(0, 2))
            0:       return COL_BLACK;
            1:       return COL_WHITE;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // Random setup: mostly real inks, alpha usually off so the ink shows.
    function automatic cfg_t draw_setup(input int phase);
        cfg_t c;
        if ($urandom_range(0, 9) < 8)
            c.ink_mode = assigned_ink($urandom_range(0, 17));
        else
            c.ink_mode = $urandom_range(0, 1) ? 6'($urandom_range(10, 31))
                                              : 6'($urandom_range(40, 63));
        c.fore_color = pick_color();
        c.back_color = pick_color();
        c.one_bit_image = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
            0:       c.blend_alpha = 8'd1;
            1:       c.blend_alpha = 8'd255;
            2:       c.blend_alpha = 8'($urandom_range(2, 254));
            default: c.blend_alpha = 8'd0;
        endcase
        c.text_sprite = ($urandom_range(0, 2) == 0);
        // pin a few phases to the corners of the setup space
        case (phase)
            0:
            begin
                c.fore_color = COL_WHITE;
                c.back_color = COL_BLACK;
                c.blend_alpha = 8'd0;
            end
            1:       c.blend_alpha = 8'd255;
            2:       c.blend_alpha = 8'd1;
            3:
            begin
                c.ink_mode = 6'd63;
                c.blend_alpha = 8'd0;
            end
            default: ;
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        cfg_t             c;
        logic [PIX_W-1:0] s;
        logic [PIX_W-1:0] d;
        int               gap;
        logic             steady;

        shadow_cfg = '{ink_mode: INK_COPY, fore_color: COL_BLACK, back_color: COL_WHITE,
                       one_bit_image: 1'b0, blend_alpha: 8'd0, text_sprite: 1'b0};

        // Directed table. Row 0 runs on the reset values without any write.
        //       ink              fore       back       1b    alpha  txt   src        dst
        add_row(INK_COPY,        COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h000000,
                1'b1, 24'hFFFFFF);
        add_row(INK_COPY,        COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h000000, 24'hFFFFFF,
                1'b1, 24'h000000);
        add_row(INK_NOT_COPY,    COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h0F0F0F, 24'h000000,
                1'b1, 24'hF0F0F0);
        add_row(INK_TRANSP,      COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h00FF00, 24'h0000FF,
                1'b1, 24'h00FFFF);
        // one-bit transparent: black source takes the fore color
        add_row(INK_TRANSP,      24'h123456, COL_WHITE, 1'b1, 8'd0,  1'b0, 24'h000000, 24'hABCDEF,
                1'b1, 24'h123456);
        add_row(INK_REVERSE,     COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h0F0F0F,
                1'b1, 24'hF0F0F0);
        add_row(INK_NOT_REVERSE, COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h0F0F0F,
                1'b1, 24'h0F0F0F);
        add_row(INK_GHOST,       COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h123456,
                1'b1, 24'h000000);
        add_row(INK_NOT_GHOST,   COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h000000, 24'h123456,
                1'b1, 24'h000000);
        add_row(INK_NOT_TRANSP,  COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h000000, 24'h000000,
                1'b1, 24'hFFFFFF);
        // colorized matte and mask
        add_row(INK_MATTE,       24'hFF0000, 24'h00FF00, 1'b0, 8'd0, 1'b0, 24'hA5C3F0, 24'h000000,
                1'b0, '0);
        add_row(INK_MASK,        24'h0000FF, 24'h808080, 1'b0, 8'd0, 1'b0, 24'h3C5A78, 24'hFFFFFF,
                1'b0, '0);
        add_row(INK_BLEND,       COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h5A5A5A, 24'h000000,
                1'b1, 24'h5A5A5A);
        add_row(INK_ADD_PIN,     COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h010101,
                1'b1, 24'hFFFFFF);
        add_row(INK_ADD,         COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h010101,
                1'b1, 24'h000000);
        // pinned subtract: max(d-s,1)-1 per channel
        add_row(INK_SUB_PIN,     COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h010203, 24'h050505,
                1'b1, 24'h030201);
        add_row(INK_SUB_PIN,     COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h000000,
                1'b1, 24'h000000);
        add_row(INK_BG_TRANSP,   COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h123456,
                1'b1, 24'h123456);
        add_row(INK_BG_TRANSP,   24'hABCDEF, COL_WHITE, 1'b1, 8'd0,  1'b0, 24'h000000, 24'h123456,
                1'b1, 24'hABCDEF);
        add_row(INK_LIGHTEN,     COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h00FF80, 24'h80007F,
                1'b1, 24'h80FF80);
        add_row(INK_SUB,         COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h010101, 24'h000000,
                1'b1, 24'hFFFFFF);
        add_row(INK_DARKEN,      COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'h00FF80, 24'h80007F,
                1'b1, 24'h00007F);
        // full alpha passes the source through, whatever the ink
        add_row(6'd63,           COL_BLACK, COL_WHITE, 1'b0, 8'd255, 1'b0, 24'h123456, 24'h000000,
                1'b1, 24'h123456);
        add_row(INK_COPY,        COL_BLACK, COL_WHITE, 1'b0, 8'd1,   1'b0, 24'hFFFFFF, 24'h7F7F7F,
                1'b0, '0);
        // unassigned ink codes keep the destination
        add_row(6'd63,           COL_BLACK, COL_WHITE, 1'b0, 8'd0,   1'b0, 24'hFFFFFF, 24'h654321,
                1'b1, 24'h654321);
        add_row(6'd10,           COL_WHITE, COL_BLACK, 1'b1, 8'd0,   1'b0, 24'h000000, 24'hFEDCBA,
                1'b1, 24'hFEDCBA);
        // text source under mask ink: background-colored text becomes fore
        add_row(INK_MASK,        24'h00FF00, 24'h102030, 1'b0, 8'd0, 1'b1, 24'h102030, 24'h000000,
                1'b0, '0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (table_rows[i])
        begin
            if (i > 0)
            begin
                stop_sending();
                drain();
                load_setup(table_rows[i].setup);
            end
            send_pixel(table_rows[i].src, table_rows[i].dst, 0,
                       table_rows[i].known, table_rows[i].result);
        end

        // Random phases. The sender goes quiet and the pipe drains before
        // each register update, which is also the full-drain pause.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            stop_sending();
            drain();
            c = draw_setup(phase);
            load_setup(c);
            steady = (phase % 3 == 0);    // every third phase runs back-to-back
            for (int n = 0; n < PIXELS_PER_PHASE; n++)
            begin
                // bias the source toward the colors the inks compare against
                case ($urandom_range(0, 7))
                    0:       s = shadow_cfg.fore_color;
                    1:       s = shadow_cfg.back_color;
                    2:       s = COL_BLACK;
                    3:       s = COL_WHITE;
                    default: s = PIX_W'($urandom);
                endcase
                case ($urandom_range(0, 5))
                    0:       d = COL_BLACK;
                    1:       d = COL_WHITE;
                    default: d = PIX_W'($urandom);
                endcase
                gap = steady ? 0 : $urandom_range(0, 8);
                send_pixel(s, d, gap, 1'b0, '0);
            end
        end

        stop_sending();
        drain();
        if (mismatches == 0)
            $display("ink_pixel_compositor: match");
        else
            $display("ink_pixel_compositor: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ipc_pkg.sv
rtl/core/ipc_prep.sv
rtl/core/ipc_ink.sv
rtl/core/ipc_blend.sv
rtl/core/ink_pixel_compositor.sv
sim/tb_ink_pixel_compositor.sv
